// File: src/brsm_pkg.sv
// shared types, constants and arithmetic helpers of the block-row sparse matvec
`timescale 1ns / 1ps

package brsm_pkg;

  // x store geometry
  localparam int X_DEPTH = 4096;
  localparam int X_AW    = $clog2(X_DEPTH);

  // most rows per block row, and the value lanes built
  localparam int BLOCK_ROWS = 3;
  localparam int LANES      = 3;
  localparam int LANE_CAP   = (BLOCK_ROWS < LANES) ? BLOCK_ROWS : LANES;

  // front to back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_NZ    = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        index;
    logic signed [31:0] x_value;
    logic signed [31:0] val_0;
    logic signed [31:0] val_1;
    logic signed [31:0] val_2;
    logic [1:0]         row_width;
    logic               last_of_row;
    logic               add_mode;
    logic signed [63:0] y_in_0;
    logic signed [63:0] y_in_1;
    logic signed [63:0] y_in_2;
  } item_t;

  typedef struct packed {
    logic [1:0]         row_offset;
    logic signed [63:0] row_sum;
    logic               last_of_run;
  } result_t;

  // one classified nonzero or close, as it waits for the back end
  typedef struct packed {
    logic                    emit;
    logic [1:0]              w;
    logic                    add;
    logic [LANES-1:0][31:0]  val;
    logic [31:0]             x;
    logic [LANES-1:0][63:0]  y;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) begin
      r = a[63] ? SAT_MIN : SAT_MAX;
    end
    return r;
  endfunction

  function automatic logic [1:0] eff_width(input logic [1:0] rw);
    logic [1:0] w;
    w = rw;
    if (w == 2'd0) begin
      w = 2'd1;
    end
    if (w > 2'(LANE_CAP)) begin
      w = 2'(LANE_CAP);
    end
    return w;
  endfunction

endpackage

// File: src/block_row_sparse_matvec.sv
// top level of the block-row sparse matrix-vector multiply
`timescale 1ns / 1ps

//  channel   handshake                  beat payload
//  item      item_valid / item_stall    item_t: load x, nonzero column, or close of a block row
//  result    result_valid / result_stall  result_t: one saturated Q32.32 row sum
//
//  the front takes one item beat every cycle while the queue has room; x store reads go
//  through the registered ram port, so a nonzero enters the queue along with its read data
//  the back takes one queued item a cycle unless a close waits for the emit stage; a block
//  row close occupies the single result port for one sum beat per row of its effective width,
//  while the next row's columns keep accumulating; a closing beat passes the f1 register, the
//  queue, the multiply stage, the emit stage and the result register before its first sum beat
//  reset (rst, synchronous) empties the queue and pipeline and zeroes the accumulators;
//  the x store is not cleared and needs its entries loaded before they are read
//  result_stall backs up through the emit stage, the multiply stage and the queue to item_stall

module block_row_sparse_matvec import brsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item_data,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_data
);

  logic     push;
  qent_t    push_data;
  logic     pop;
  qent_t    head;
  q_flags_t q_flags;

  // classifier and x store
  brsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_data  (item_data),
    .push       (push),
    .push_data  (push_data),
    .q_flags    (q_flags)
  );

  // decoupling queue
  brsm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .flags     (q_flags)
  );

  // multiply-accumulate lanes and sum serializer
  brsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .flags        (q_flags),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

`ifndef ASSERT_OFF
  // front never overruns the queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_flags.full |-> !push)
    else $error("push into full queue");

  // back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_flags.empty |-> !pop)
    else $error("pop from empty queue");

  // a load beat leaves nothing staged for the queue
  a_load_no_push: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (item_data.action == ACT_LOAD)) |=> !push)
    else $error("load beat produced queue work");
`endif

endmodule

// File: src/brsm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module brsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/brsm_front.sv
// front end: takes items, writes and reads the x store, classifies work for the back end
`timescale 1ns / 1ps

module brsm_front import brsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  item_t    item_data,
  output logic     push,
  output qent_t    push_data,
  input  q_flags_t q_flags
);

  logic             accept;
  logic             in_range;
  logic             is_work;
  logic [X_AW-1:0]  addr;
  logic [31:0]      ram_rdata;

  logic             f1_valid;
  logic             f1_valid_next;
  logic             f1_xok;
  qent_t            f1_ent;

  assign item_stall = f1_valid && q_flags.full;
  assign accept     = item_valid && !item_stall;
  assign in_range   = (32'(item_data.index) < 32'(X_DEPTH));
  assign addr       = X_AW'(item_data.index);
  assign is_work    = (item_data.action == ACT_NZ) || (item_data.action == ACT_CLOSE);
  assign push       = f1_valid && !q_flags.full;

  brsm_ram #(
    .WIDTH (32),
    .DEPTH (X_DEPTH)
  ) u_xstore (
    .clk   (clk),
    .we    (accept && (item_data.action == ACT_LOAD) && in_range),
    .waddr (addr),
    .wdata (item_data.x_value),
    .re    (accept && (item_data.action == ACT_NZ)),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    f1_valid_next = f1_valid;
    if (push) begin
      f1_valid_next = 1'b0;
    end
    if (accept && is_work) begin
      f1_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= f1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_work) begin
      f1_ent.emit <= (item_data.action == ACT_CLOSE) || item_data.last_of_row;
      f1_ent.w    <= eff_width(item_data.row_width);
      f1_ent.add  <= item_data.add_mode;
      f1_ent.val  <= {item_data.val_2, item_data.val_1, item_data.val_0};
      f1_ent.x    <= '0;
      f1_ent.y    <= {item_data.y_in_2, item_data.y_in_1, item_data.y_in_0};
      f1_xok      <= (item_data.action == ACT_NZ) && in_range;
    end
  end

  // close items and columns past the store see zero
  always_comb begin
    push_data   = f1_ent;
    push_data.x = f1_xok ? ram_rdata : '0;
  end

endmodule

// File: src/brsm_queue.sv
// short register queue between front and back
`timescale 1ns / 1ps

module brsm_queue import brsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  qent_t    push_data,
  input  logic     pop,
  output qent_t    head,
  output q_flags_t flags
);

  qent_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic [QAW:0]   count_next;

  assign head        = mem[rd_ptr];
  assign flags.full  = (count == (QAW+1)'(QDEPTH));
  assign flags.empty = (count == '0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_next = count - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/brsm_back.sv
// back end: lane multipliers, saturating accumulators and the sum serializer
`timescale 1ns / 1ps

module brsm_back import brsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  qent_t    head,
  input  q_flags_t flags,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result_data
);

  // multiply stage
  logic                   b1_valid;
  logic                   b1_emit;
  logic [1:0]             b1_w;
  logic                   b1_add;
  logic [63:0]            b1_p [LANES];
  logic [LANES-1:0][63:0] b1_y;
  logic                   b1_go;
  logic signed [63:0]     prod [LANES];

  // accumulators
  logic [63:0] acc      [LANES];
  logic [63:0] acc_next [LANES];

  // emit stage
  logic                   em_valid;
  logic [1:0]             em_cnt;
  logic [1:0]             em_w;
  logic                   em_add;
  logic [63:0]            em_fin [LANES];
  logic [LANES-1:0][63:0] em_y;
  logic                   em_fire;
  logic                   em_last;
  logic                   em_free;
  logic                   out_load;
  logic [63:0]            em_sum;

  assign out_load = !result_valid || !result_stall;
  assign em_fire  = em_valid && out_load;
  assign em_last  = (em_cnt == em_w - 2'd1);
  assign em_free  = !em_valid || (em_fire && em_last);
  assign b1_go    = b1_valid && (!b1_emit || em_free);
  assign pop      = !flags.empty && (!b1_valid || b1_go);

  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] xv;
    for (int k = 0; k < LANES; k++) begin
      a       = head.val[k];
      xv      = head.x;
      prod[k] = a * xv;
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      acc_next[k] = (2'(k) < b1_w) ? sat_add(acc[k], b1_p[k]) : acc[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (pop) begin
      b1_valid <= 1'b1;
    end else if (b1_go) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_emit <= head.emit;
      b1_w    <= head.w;
      b1_add  <= head.add;
      b1_y    <= head.y;
      for (int k = 0; k < LANES; k++) begin
        b1_p[k] <= prod[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANES; k++) begin
        acc[k] <= '0;
      end
    end else if (b1_go) begin
      for (int k = 0; k < LANES; k++) begin
        acc[k] <= b1_emit ? '0 : acc_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      em_cnt   <= '0;
    end else if (b1_go && b1_emit) begin
      em_valid <= 1'b1;
      em_cnt   <= '0;
    end else if (em_fire && em_last) begin
      em_valid <= 1'b0;
    end else if (em_fire) begin
      em_cnt <= em_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_go && b1_emit) begin
      em_w   <= b1_w;
      em_add <= b1_add;
      em_y   <= b1_y;
      for (int k = 0; k < LANES; k++) begin
        em_fin[k] <= acc_next[k];
      end
    end
  end

  assign em_sum = em_add ? sat_add(em_fin[em_cnt], em_y[em_cnt]) : em_fin[em_cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= em_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (em_fire) begin
      result_data.row_offset  <= em_cnt;
      result_data.row_sum     <= em_sum;
      result_data.last_of_run <= em_last;
    end
  end

endmodule
